### sv/pns_pkg.sv
// Package for the polyline normal block: shared constants, command and status types.
// No dependencies; used by pns_ctrl, pns_datapath and polyline_normal_smoothing.
`default_nettype none
package pns_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_BITS_DEF = 16;

  // Port and internal widths
  localparam int IN_W   = 16;   // coordinate port width
  localparam int CW     = 17;   // internal coordinate width (sign or zero extended)
  localparam int DW     = 18;   // difference width
  localparam int SQ_W   = 36;   // one square
  localparam int S_W    = 37;   // sum of squares
  localparam int X_W    = 54;   // sqrt radicand (s << 16), rounded to an even bit count
  localparam int SQ_STEPS = 27; // one result bit per step
  localparam int R_W    = 27;   // sqrt result width
  localparam int Q_W    = 16;   // quotient bits computed per lane
  localparam int REM_W  = 43;   // remainder and shifted divisor width
  localparam int IDX_W  = 10;   // point_index port width
  localparam int OUT_W  = 16;
  localparam logic [Q_W-1:0] NORM_ONE = 16'd16384;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // take an input word
    logic sel_b;     // work on the end point result
    logic mul;       // square the differences
    logic sq_init;   // form the radicand
    logic sq_step;   // one square root step
    logic div_init;  // load the dividers
    logic div_step;  // one quotient bit per lane
    logic write;     // load the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic has_a;     // the word makes a first result
    logic has_b;     // the word makes a second result
    logic zero;      // sum of squares is zero
    logic sq_done;   // last square root step
    logic div_done;  // last quotient bit
    logic out_free;  // output register can take a word
  } sts_t;

endpackage
`default_nettype wire

### sv/polyline_normal_smoothing.sv
// Polyline vertex normals: one result per point, one point late, two on end of line.
// Steps per word: start, then for each result square, radicand, 27 root steps, divider
// load, 16 divide steps and output load; a word with no result ends after start.
// No new word is taken until every result of a word is written; a zero-length result
// skips the root and divide steps, and a stalled output register holds the write.
// Reset (rst, synchronous) clears history, count and output valid. Uses pns_ctrl, pns_datapath.
`default_nettype none
module polyline_normal_smoothing #(
  parameter int MAX_POINTS = pns_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = pns_pkg::COORD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [pns_pkg::IN_W-1:0]   coord_y,
  input  wire logic signed [pns_pkg::IN_W-1:0]   coord_z,
  input  wire logic                              end_of_line,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [pns_pkg::OUT_W-1:0]       normal_y,
  output logic signed [pns_pkg::OUT_W-1:0]       normal_z,
  output logic        [pns_pkg::IDX_W-1:0]       point_index,
  output logic                                   degenerate,
  output logic                                   run_last
);

  pns_pkg::cmd_t cmd;
  pns_pkg::sts_t sts;

  pns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pns_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .end_of_line (end_of_line),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .normal_y    (normal_y),
    .normal_z    (normal_z),
    .point_index (point_index),
    .degenerate  (degenerate),
    .run_last    (run_last)
  );

endmodule
`default_nettype wire

### sv/pns_ctrl.sv
// Controller state machine for the polyline normal block.
// Depends on pns_pkg for cmd_t and sts_t.
`default_nettype none
module pns_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  pns_pkg::sts_t      sts,
  output pns_pkg::cmd_t      cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_START = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_SQI   = 8'b0000_1000,
    S_SQRT  = 8'b0001_0000,
    S_DVI   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_WRITE = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   job_b, job_b_next;

  assign in_stall = (state != S_IDLE);

  // Sequence the work of one input word
  always_comb begin
    state_next = state;
    job_b_next = job_b;
    cmd        = '0;
    cmd.sel_b  = job_b;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        job_b_next = 1'b0;
        state_next = sts.has_a ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SQI;
      end
      S_SQI: begin
        cmd.sq_init = 1'b1;
        state_next  = sts.zero ? S_WRITE : S_SQRT;
      end
      S_SQRT: begin
        cmd.sq_step = 1'b1;
        if (sts.sq_done) state_next = S_DVI;
      end
      S_DVI: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_next = S_WRITE;
      end
      S_WRITE: begin
        if (sts.out_free) begin
          cmd.write = 1'b1;
          if (!job_b && sts.has_b) begin
            job_b_next = 1'b1;
            state_next = S_MUL;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      job_b <= 1'b0;
    end else begin
      state <= state_next;
      job_b <= job_b_next;
    end
  end

  a_load_start: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_START)
    else $error("load not followed by start");
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> sts.out_free)
    else $error("output written while occupied");
  a_second_eol: assert property (@(posedge clk) disable iff (rst)
    (cmd.write && job_b) |=> state == S_IDLE)
    else $error("end point result not last");

endmodule
`default_nettype wire

### sv/pns_datapath.sv
// Datapath for the polyline normal block: point history, squares, square root,
// two dividers and the output register. Depends on pns_pkg.
`default_nettype none
module pns_datapath #(
  parameter int MAX_POINTS = pns_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = pns_pkg::COORD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic signed [pns_pkg::IN_W-1:0]   coord_y,
  input  wire logic signed [pns_pkg::IN_W-1:0]   coord_z,
  input  wire logic                              end_of_line,
  input  pns_pkg::cmd_t                          cmd,
  output pns_pkg::sts_t                          sts,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [pns_pkg::OUT_W-1:0]       normal_y,
  output logic signed [pns_pkg::OUT_W-1:0]       normal_z,
  output logic        [pns_pkg::IDX_W-1:0]       point_index,
  output logic                                   degenerate,
  output logic                                   run_last
);

  localparam int CW    = pns_pkg::CW;
  localparam int DW    = pns_pkg::DW;
  localparam int CNT_W = $clog2(MAX_POINTS);
  localparam int SB    = (COORD_BITS <= pns_pkg::IN_W) ? COORD_BITS - 1 : pns_pkg::IN_W - 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS - 1);
  localparam int SQC_W = $clog2(pns_pkg::SQ_STEPS);
  localparam int DVC_W = $clog2(pns_pkg::Q_W);

  // Extend the coordinates as the configured width reads them
  logic [CW-1:0] yz, zz, ey, ez;
  always_comb begin
    yz = {1'b0, coord_y};
    zz = {1'b0, coord_z};
    for (int i = 0; i < CW; i++) begin
      if (i < COORD_BITS) begin
        ey[i] = yz[i];
        ez[i] = zz[i];
      end else begin
        ey[i] = (COORD_BITS <= pns_pkg::IN_W) ? yz[SB] : 1'b0;
        ez[i] = (COORD_BITS <= pns_pkg::IN_W) ? zz[SB] : 1'b0;
      end
    end
  end

  // Point history and count
  logic signed [CW-1:0] prev_y, prev_z, prev2_y, prev2_z;
  logic [CNT_W-1:0]     point_count;
  logic signed [DW-1:0] d0y, d0z, d1y, d1z;
  logic [CNT_W-1:0]     idx_a, idx_b;
  logic                 last_a, has_a, has_b;

  logic n0, n1;
  logic signed [DW-1:0] dpy, dpz, dqy, dqz;
  assign n0  = (point_count == '0);
  assign n1  = (point_count == CNT_W'(1));
  assign dpy = DW'($signed(ey)) - DW'(prev_y);
  assign dpz = DW'($signed(ez)) - DW'(prev_z);
  assign dqy = DW'($signed(ey)) - DW'(prev2_y);
  assign dqz = DW'($signed(ez)) - DW'(prev2_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_y <= '0; prev_z <= '0; prev2_y <= '0; prev2_z <= '0;
      point_count <= '0;
      has_a <= 1'b0;
      has_b <= 1'b0;
    end else if (cmd.load) begin
      d0y    <= n0 ? '0 : (n1 ? dpy : dqy);
      d0z    <= n0 ? '0 : (n1 ? dpz : dqz);
      d1y    <= dpy;
      d1z    <= dpz;
      idx_a  <= n0 ? '0 : point_count - CNT_W'(1);
      idx_b  <= point_count;
      last_a <= n0 | ~end_of_line;
      has_a  <= ~n0 | end_of_line;
      has_b  <= ~n0 & end_of_line;
      prev2_y <= prev_y;
      prev2_z <= prev_z;
      prev_y  <= $signed(ey);
      prev_z  <= $signed(ez);
      if (end_of_line) point_count <= '0;
      else if (point_count < CNT_MAX) point_count <= point_count + CNT_W'(1);
    end
  end

  // Square the selected differences
  logic signed [DW-1:0] wy, wz, my, mz;
  logic [CNT_W-1:0]     idx_w;
  logic                 last_w;
  logic [pns_pkg::SQ_W-1:0] sqy, sqz;
  logic signed [pns_pkg::SQ_W-1:0] py, pz;
  assign my = cmd.sel_b ? d1y : d0y;
  assign mz = cmd.sel_b ? d1z : d0z;
  assign py = my * my;
  assign pz = mz * mz;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      wy     <= my;
      wz     <= mz;
      idx_w  <= cmd.sel_b ? idx_b : idx_a;
      last_w <= cmd.sel_b ? 1'b1 : last_a;
      sqy    <= py;
      sqz    <= pz;
    end
  end

  // Square root, one result bit per step
  logic [pns_pkg::S_W-1:0] s_sum;
  logic [pns_pkg::X_W-1:0] sq_x, sq_res, sq_bit, sq_try;
  logic [SQC_W-1:0]        sq_cnt;
  logic                    deg;
  assign s_sum  = {1'b0, sqy} + {1'b0, sqz};
  assign sq_try = sq_res + sq_bit;

  always_ff @(posedge clk) begin
    if (cmd.sq_init) begin
      sq_x   <= pns_pkg::X_W'({s_sum, 16'b0});
      sq_res <= '0;
      sq_bit <= pns_pkg::X_W'(1) << (2 * (pns_pkg::SQ_STEPS - 1));
      sq_cnt <= SQC_W'(pns_pkg::SQ_STEPS - 1);
      deg    <= (s_sum == '0);
    end else if (cmd.sq_step) begin
      if (sq_x >= sq_try) begin
        sq_x   <= sq_x - sq_try;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
      sq_cnt <= sq_cnt - SQC_W'(1);
    end
  end

  // Two restoring dividers share the root as divisor
  logic [pns_pkg::R_W-1:0]   root;
  logic [DW-1:0]             mag_y, mag_z;
  logic [pns_pkg::REM_W-1:0] rem_y, rem_z, dsr;
  logic [pns_pkg::Q_W-1:0]   q_y, q_z;
  logic                      sat_y, sat_z, neg_y, neg_z;
  logic [DVC_W-1:0]          dv_cnt;
  assign root  = sq_res[pns_pkg::R_W-1:0];
  assign mag_y = wz[DW-1] ? DW'(-wz) : DW'(wz);
  assign mag_z = wy[DW-1] ? DW'(-wy) : DW'(wy);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      sat_y  <= pns_pkg::REM_W'({mag_y, 6'b0}) >= pns_pkg::REM_W'(root);
      sat_z  <= pns_pkg::REM_W'({mag_z, 6'b0}) >= pns_pkg::REM_W'(root);
      rem_y  <= pns_pkg::REM_W'({mag_y, 22'b0});
      rem_z  <= pns_pkg::REM_W'({mag_z, 22'b0});
      dsr    <= pns_pkg::REM_W'({root, 15'b0});
      q_y    <= '0;
      q_z    <= '0;
      neg_y  <= ~wz[DW-1];
      neg_z  <= wy[DW-1];
      dv_cnt <= DVC_W'(pns_pkg::Q_W - 1);
    end else if (cmd.div_step) begin
      if (rem_y >= dsr) begin
        rem_y <= rem_y - dsr;
        q_y   <= {q_y[pns_pkg::Q_W-2:0], 1'b1};
      end else begin
        q_y   <= {q_y[pns_pkg::Q_W-2:0], 1'b0};
      end
      if (rem_z >= dsr) begin
        rem_z <= rem_z - dsr;
        q_z   <= {q_z[pns_pkg::Q_W-2:0], 1'b1};
      end else begin
        q_z   <= {q_z[pns_pkg::Q_W-2:0], 1'b0};
      end
      dsr    <= dsr >> 1;
      dv_cnt <= dv_cnt - DVC_W'(1);
    end
  end

  // Saturate, apply the sign, drop to zero when degenerate
  logic [pns_pkg::Q_W-1:0] cy, cz, ny, nz;
  logic [CNT_W+pns_pkg::IDX_W-1:0] idx_ext;
  assign cy = (sat_y || q_y > pns_pkg::NORM_ONE) ? pns_pkg::NORM_ONE : q_y;
  assign cz = (sat_z || q_z > pns_pkg::NORM_ONE) ? pns_pkg::NORM_ONE : q_z;
  assign ny = deg ? '0 : (neg_y ? -cy : cy);
  assign nz = deg ? '0 : (neg_z ? -cz : cz);
  assign idx_ext = {{pns_pkg::IDX_W{1'b0}}, idx_w};

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      normal_y    <= $signed(ny);
      normal_z    <= $signed(nz);
      point_index <= idx_ext[pns_pkg::IDX_W-1:0];
      degenerate  <= deg;
      run_last    <= last_w;
    end
  end

  always_comb begin
    sts          = '0;
    sts.has_a    = has_a;
    sts.has_b    = has_b;
    sts.zero     = (s_sum == '0);
    sts.sq_done  = (sq_cnt == '0);
    sts.div_done = (dv_cnt == '0);
    sts.out_free = ~out_valid | ~out_stall;
  end

  a_root_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_init && !deg) |-> root != '0)
    else $error("zero divisor");
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.write && deg) |=> (normal_y == '0 && normal_z == '0))
    else $error("degenerate normal not zero");
  a_second_has_first: assert property (@(posedge clk) disable iff (rst)
    has_b |-> has_a)
    else $error("second result without first");

endmodule
`default_nettype wire

### tb/pns_checker.sv
// Checker for polyline_normal_smoothing: watches both channels, predicts each normal
// word from the accepted points and compares it field by field. Uses pns_pkg widths.
`default_nettype none
module pns_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  input  wire logic                            in_stall,
  input  wire logic signed [pns_pkg::IN_W-1:0] coord_y,
  input  wire logic signed [pns_pkg::IN_W-1:0] coord_z,
  input  wire logic                            end_of_line,
  input  wire logic                            out_valid,
  input  wire logic                            out_stall,
  input  wire logic signed [pns_pkg::OUT_W-1:0] normal_y,
  input  wire logic signed [pns_pkg::OUT_W-1:0] normal_z,
  input  wire logic        [pns_pkg::IDX_W-1:0] point_index,
  input  wire logic                            degenerate,
  input  wire logic                            run_last,
  output int                                   fails,
  output int                                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAST_IDX = 1023;

  typedef struct {
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [9:0]         idx;
    logic               deg;
    logic               last;
  } normal_word_t;

  normal_word_t normals_due[$];

  // point history and count of the current line
  longint hist_y, hist_z, hist2_y, hist2_z;
  int     line_count;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= root + b) begin
        x = x - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // one Q1.14 component: truncate toward zero, saturate to one
  function automatic logic [15:0] q14_part(longint v, longint unsigned r);
    longint unsigned mag, q;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    q = (mag << 22) / r;
    if (q > 64'd16384) q = 64'd16384;
    if (v < 0) q = -q;
    return q[15:0];
  endfunction

  function automatic normal_word_t unit_normal(longint dy, longint dz, int idx,
                                               bit force_deg, bit last);
    normal_word_t w;
    longint unsigned s, r;
    s = longint'(dy * dy) + longint'(dz * dz);
    if (force_deg || s == 0) begin
      w.ny = '0;
      w.nz = '0;
      w.deg = 1'b1;
    end else begin
      r = int_sqrt(s << 16);
      w.ny = q14_part(-dz, r);
      w.nz = q14_part(dy, r);
      w.deg = 1'b0;
    end
    w.idx = idx[9:0];
    w.last = last;
    return w;
  endfunction

  always @(posedge clk) begin
    normal_word_t got, want;
    longint y, z;
    if (rst) begin
      hist_y = 0; hist_z = 0; hist2_y = 0; hist2_z = 0;
      line_count = 0;
      normals_due.delete();
      fails = 0;
    end else begin
      // compare a delivered normal with the oldest prediction
      if (out_valid && !out_stall) begin
        got = '{normal_y, normal_z, point_index, degenerate, run_last};
        if (normals_due.size() == 0) begin
          $error("unexpected normal word idx=%0d", point_index);
          fails++;
        end else begin
          want = normals_due.pop_front();
          if (got.ny !== want.ny) begin
            $error("normal_y exp %0d got %0d", want.ny, got.ny); fails++;
          end
          if (got.nz !== want.nz) begin
            $error("normal_z exp %0d got %0d", want.nz, got.nz); fails++;
          end
          if (got.idx !== want.idx) begin
            $error("point_index exp %0d got %0d", want.idx, got.idx); fails++;
          end
          if (got.deg !== want.deg) begin
            $error("degenerate exp %0d got %0d", want.deg, got.deg); fails++;
          end
          if (got.last !== want.last) begin
            $error("run_last exp %0d got %0d", want.last, got.last); fails++;
          end
        end
      end
      // predict the normals caused by an accepted point
      if (in_valid && !in_stall) begin
        y = longint'(coord_y);
        z = longint'(coord_z);
        if (line_count == 0) begin
          if (end_of_line) normals_due.push_back(unit_normal(0, 0, 0, 1, 1));
        end else if (line_count == 1) begin
          normals_due.push_back(unit_normal(y - hist_y, z - hist_z, 0, 0, !end_of_line));
          if (end_of_line)
            normals_due.push_back(unit_normal(y - hist_y, z - hist_z, 1, 0, 1));
        end else begin
          normals_due.push_back(unit_normal(y - hist2_y, z - hist2_z, line_count - 1, 0,
                                            !end_of_line));
          if (end_of_line)
            normals_due.push_back(unit_normal(y - hist_y, z - hist_z, line_count, 0, 1));
        end
        hist2_y = hist_y; hist2_z = hist_z;
        hist_y = y; hist_z = z;
        if (end_of_line) line_count = 0;
        else if (line_count < LAST_IDX) line_count++;
      end
    end
    pending = normals_due.size();
  end

endmodule
`default_nettype wire

### tb/polyline_normal_smoothing_tb.sv
// Top of the polyline normal testbench: clock, reset, point stimulus and verdict.
// Depends on pns_pkg, polyline_normal_smoothing and pns_checker.
`default_nettype none
module polyline_normal_smoothing_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_POINTS = 630;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int LONG_HOLD = 600;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] coord_y = 0;
  logic signed [15:0] coord_z = 0;
  logic end_of_line = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] normal_y, normal_z;
  logic [9:0] point_index;
  logic degenerate, run_last;
  int fails, pending;
  int points_sent = 0;
  int cycles = 0;
  bit hold_wanted = 0;
  logic signed [15:0] last_y = 0, last_z = 0;

  polyline_normal_smoothing dut (.*);

  pns_checker checker_i (.*);

  always #5 clk = ~clk;

  // bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // offer one point word and hold it until taken
  task automatic put_point(logic signed [15:0] y, logic signed [15:0] z, logic eol);
    in_valid <= 1'b1;
    coord_y <= y;
    coord_z <= z;
    end_of_line <= eol;
    last_y = y;
    last_z = z;
    do @(posedge clk); while (in_stall);
    points_sent++;
  endtask

  // random gap after a word in one case of three; none otherwise
  task automatic maybe_gap();
    int gap;
    if ($urandom_range(0, 2) != 0) return;
    gap = $urandom_range(1, 12);
    in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // stop offering and hold until every predicted normal has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // next coordinate: full range, a small step, or the same point again
  task automatic next_coord(output logic signed [15:0] y, output logic signed [15:0] z);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin y = 16'($urandom); z = 16'($urandom); end
      4: begin y = last_y; z = last_z; end
      5: begin y = 16'(last_y + $urandom_range(0, 4) - 2); z = last_z; end
      default: begin
        y = 16'(last_y + $urandom_range(0, 512) - 256);
        z = 16'(last_z + $urandom_range(0, 512) - 256);
      end
    endcase
  endtask

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode, len;
    bit held;
    held = 0;
    @(negedge rst);
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(20, 200);
      repeat (len) begin
        @(posedge clk);
        if (hold_wanted && !held) begin
          out_stall <= 1'b1;
          repeat (LONG_HOLD) @(posedge clk);
          held = 1;
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 1);
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    logic signed [15:0] y, z;
    int len, start;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: one-point line, extreme segment, zero length, short lines
    put_point(16'sh1234, -16'sd7, 1'b1);
    put_point(-16'sd32768, -16'sd32768, 1'b0);
    put_point(16'sd32767, 16'sd32767, 1'b1);
    put_point(16'sd32767, -16'sd32768, 1'b0);
    put_point(-16'sd32768, 16'sd32767, 1'b1);
    put_point(16'sd5, 16'sd5, 1'b0);
    put_point(16'sd5, 16'sd5, 1'b1);
    put_point(16'sd0, 16'sd0, 1'b0);
    put_point(16'sd100, 16'sd0, 1'b0);
    put_point(16'sd0, 16'sd0, 1'b0);
    put_point(16'sd0, -16'sd100, 1'b0);
    put_point(-16'sd1, 16'sd1, 1'b1);
    put_point(16'sd0, 16'sd0, 1'b0);
    put_point(16'sd1, 16'sd0, 1'b0);
    put_point(16'sd2, 16'sd0, 1'b1);
    put_point(-16'sd32768, 16'sd0, 1'b0);
    put_point(16'sd32767, 16'sd0, 1'b0);
    put_point(-16'sd32768, 16'sd1, 1'b1);
    put_point(16'sd0, 16'sd0, 1'b1);

    // drain completely once before the random part
    drain();

    // random polylines
    start = points_sent;
    while (points_sent - start < RANDOM_POINTS) begin
      len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
      for (int i = 0; i < len; i++) begin
        next_coord(y, z);
        // stray end marks break a line early now and then
        put_point(y, z, (i == len - 1) || ($urandom_range(0, 40) == 0));
        maybe_gap();
        if (points_sent - start == 60) hold_wanted = 1;
      end
      if (points_sent - start > 300 && points_sent - start < 320) drain();
    end

    drain();
    repeat (200) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire

### polyline_normal_smoothing.f
sv/pns_pkg.sv
sv/pns_ctrl.sv
sv/pns_datapath.sv
sv/polyline_normal_smoothing.sv
tb/pns_checker.sv
tb/polyline_normal_smoothing_tb.sv
